// File: rtl/core/tccw_pkg.sv
package tccw_pkg;

   // fixed field widths
   localparam int CMD_W   = 3;
   localparam int CHAR_W  = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int SCRL_W  = 8;
   localparam int LINES_W = 6;   // clamped scroll count, up to 32 rows
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = CHAR_W + ATTR_W;

   // geometry defaults
   localparam int DEFAULT_COLUMNS   = 80;
   localparam int DEFAULT_ROWS      = 25;
   localparam int DEFAULT_TAB_WIDTH = 4;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET = 8'h07;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE_CHAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SCROLL_UP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_CELL  = 3'd4;

   // control characters
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LAST_PRINT = 8'h7F;

   // csr register indexes
   localparam logic REG_TEXT_ATTR = 1'b0;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_PUT,
      OP_NEWLINE,
      OP_CR,
      OP_TAB,
      OP_BACKSPACE,
      OP_CLEAR,
      OP_SET_CURSOR,
      OP_SCROLL,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      logic [COL_W-1:0]    column;
      logic [ROW_W-1:0]    row;
      logic [LINES_W-1:0]  lines;
      logic                bad;
   } entry_type;

   typedef struct packed {
      logic                status;
      logic [COL_W-1:0]    cursor_column;
      logic [ROW_W-1:0]    cursor_row;
      logic [CHAR_W-1:0]   cell_char;
      logic [ATTR_W-1:0]   cell_attribute;
   } result_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_TAB,
      B_READ,
      B_COPY_RD,
      B_COPY_WR,
      B_FILL
   } back_state_type;

endpackage

// File: rtl/core/tccw_ram.sv
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

// File: rtl/core/tccw_front.sv
module tccw_front #(
   parameter int COLUMNS = tccw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tccw_pkg::DEFAULT_ROWS
) (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [31:0]              req_tdata,
   input  logic [tccw_pkg::CMD_W-1:0] req_tuser,
   output logic                     push_valid,
   input  logic                     push_ready,
   output tccw_pkg::entry_type      push_entry
);

   logic [tccw_pkg::CHAR_W-1:0] char_code;
   logic [tccw_pkg::COL_W-1:0]  column;
   logic [tccw_pkg::ROW_W-1:0]  row;
   logic [tccw_pkg::SCRL_W-1:0] scroll_count;
   logic [tccw_pkg::LINES_W-1:0] lines_clamped;
   logic                        bad_coord;
   tccw_pkg::op_type            op;

   assign char_code    = req_tdata[7:0];
   assign column       = req_tdata[14:8];
   assign row          = req_tdata[19:15];
   assign scroll_count = req_tdata[27:20];

   assign bad_coord = ({1'b0, column} >= 8'(COLUMNS)) || ({1'b0, row} >= 6'(ROWS));
   assign lines_clamped = (scroll_count > 8'(ROWS)) ? tccw_pkg::LINES_W'(ROWS)
                                                    : scroll_count[tccw_pkg::LINES_W-1:0];

   always_comb begin
      op = tccw_pkg::OP_NOP;
      unique case (req_tuser)
         tccw_pkg::CMD_WRITE_CHAR: begin
            case (char_code) inside
               tccw_pkg::CHAR_NEWLINE:   op = tccw_pkg::OP_NEWLINE;
               tccw_pkg::CHAR_CR:        op = tccw_pkg::OP_CR;
               tccw_pkg::CHAR_TAB:       op = tccw_pkg::OP_TAB;
               tccw_pkg::CHAR_BACKSPACE: op = tccw_pkg::OP_BACKSPACE;
               [tccw_pkg::CHAR_SPACE:tccw_pkg::CHAR_LAST_PRINT]: op = tccw_pkg::OP_PUT;
               default:                  op = tccw_pkg::OP_NOP;
            endcase
         end
         tccw_pkg::CMD_CLEAR:      op = tccw_pkg::OP_CLEAR;
         tccw_pkg::CMD_SET_CURSOR: op = tccw_pkg::OP_SET_CURSOR;
         tccw_pkg::CMD_SCROLL_UP: begin
            op = (scroll_count == '0) ? tccw_pkg::OP_NOP : tccw_pkg::OP_SCROLL;
         end
         tccw_pkg::CMD_READ_CELL:  op = tccw_pkg::OP_READ;
         default:                  op = tccw_pkg::OP_NOP;
      endcase
   end

   assign push_entry.op        = op;
   assign push_entry.char_code = char_code;
   assign push_entry.column    = column;
   assign push_entry.row       = row;
   assign push_entry.lines     = lines_clamped;
   assign push_entry.bad       = bad_coord;

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// File: rtl/core/tccw_queue.sv
module tccw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tccw_pkg::entry_type push_entry,
   output logic                head_valid,
   input  logic                pop,
   output tccw_pkg::entry_type head_entry
);

   localparam int DEPTH = tccw_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tccw_pkg::entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/tccw_back.sv
module tccw_back #(
   parameter int COLUMNS   = tccw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS      = tccw_pkg::DEFAULT_ROWS,
   parameter int TAB_WIDTH = tccw_pkg::DEFAULT_TAB_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tccw_pkg::ATTR_W-1:0]  text_attr,
   input  logic                         head_valid,
   input  tccw_pkg::entry_type          head_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tccw_pkg::result_type         rsp_result
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = tccw_pkg::COL_W;
   localparam int ROW_W      = tccw_pkg::ROW_W;
   localparam int LINES_W    = tccw_pkg::LINES_W;
   localparam int CELL_W     = tccw_pkg::CELL_W;
   // column / TAB_WIDTH through a reciprocal, exact for 7-bit columns
   localparam int TAB_SHIFT  = 12;
   localparam int RECIP_W    = TAB_SHIFT + 1;
   localparam int TAB_RECIP  = ((1 << TAB_SHIFT) + TAB_WIDTH - 1) / TAB_WIDTH;
   localparam int PROD_W     = COL_W + RECIP_W;
   localparam int NEXT_W     = 12;

   tccw_pkg::back_state_type state_ff, state_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    line_ff, line_in;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic [ADDR_W-1:0]   off_ff, off_in;
   logic [ADDR_W-1:0]   end_ff, end_in;
   logic [tccw_pkg::ATTR_W-1:0] fill_attr_ff, fill_attr_in;
   logic                respond_ff, respond_in;
   logic [COL_W-1:0]    tab_q_ff, tab_q_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tccw_pkg::result_type rsp_ff, rsp_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [CELL_W-1:0]   wr_data, rd_data;
   logic [ADDR_W-1:0]   cur_addr, head_addr;
   logic                out_free, out_load, out_status;
   logic [7:0]          out_char, out_attr;
   logic                nl_req, scroll_req;
   logic [LINES_W-1:0]  sc_lines, keep_rows;
   logic [ADDR_W:0]     off_full;
   logic [7:0]          col_inc;
   logic [PROD_W-1:0]   tab_prod;
   logic [NEXT_W-1:0]   tab_next;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
   endfunction

   assign cur_addr  = cell_addr(line_ff, col_ff);
   assign head_addr = cell_addr(head_entry.row, head_entry.column);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign col_inc   = {1'b0, col_ff} + 8'd1;
   assign tab_prod  = PROD_W'(col_ff) * PROD_W'(TAB_RECIP);
   assign tab_next  = (NEXT_W'(tab_q_ff) + NEXT_W'(1)) * NEXT_W'(TAB_WIDTH);
   assign keep_rows = LINES_W'(ROWS) - sc_lines;
   assign off_full  = (ADDR_W + 1)'(sc_lines) * (ADDR_W + 1)'(COLUMNS);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      ptr_in       = ptr_ff;
      off_in       = off_ff;
      end_in       = end_ff;
      fill_attr_in = fill_attr_ff;
      respond_in   = respond_ff;
      tab_q_in     = tab_q_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cur_addr;
      wr_data      = {text_attr, tccw_pkg::CHAR_SPACE};
      rd_addr      = head_addr;
      out_load     = 1'b0;
      out_status   = 1'b0;
      out_char     = '0;
      out_attr     = '0;
      nl_req       = 1'b0;
      scroll_req   = 1'b0;
      sc_lines     = LINES_W'(1);

      unique case (state_ff)
         tccw_pkg::B_IDLE: begin
            if (head_valid && out_free) begin
               pop = 1'b1;
               unique case (head_entry.op)
                  tccw_pkg::OP_PUT: begin
                     wr_en   = 1'b1;
                     wr_data = {text_attr, head_entry.char_code};
                     col_in  = col_inc[COL_W-1:0];
                     if (col_inc >= 8'(COLUMNS)) begin
                        nl_req = 1'b1;
                     end else begin
                        out_load = 1'b1;
                     end
                  end
                  tccw_pkg::OP_NEWLINE: nl_req = 1'b1;
                  tccw_pkg::OP_CR: begin
                     col_in   = '0;
                     out_load = 1'b1;
                  end
                  tccw_pkg::OP_TAB: begin
                     tab_q_in = tab_prod[TAB_SHIFT +: COL_W];
                     state_in = tccw_pkg::B_TAB;
                  end
                  tccw_pkg::OP_BACKSPACE: begin
                     // the cell before the cursor, across a row boundary too
                     wr_addr = cur_addr - 1'b1;
                     if (col_ff != '0) begin
                        wr_en  = 1'b1;
                        col_in = col_ff - 1'b1;
                     end else if (line_ff != '0) begin
                        wr_en   = 1'b1;
                        line_in = line_ff - 1'b1;
                        col_in  = COL_W'(COLUMNS - 1);
                     end
                     out_load = 1'b1;
                  end
                  tccw_pkg::OP_CLEAR: begin
                     col_in       = '0;
                     line_in      = '0;
                     ptr_in       = '0;
                     fill_attr_in = text_attr;
                     respond_in   = 1'b1;
                     state_in     = tccw_pkg::B_FILL;
                  end
                  tccw_pkg::OP_SET_CURSOR: begin
                     if (head_entry.bad) begin
                        out_status = 1'b1;
                     end else begin
                        col_in  = head_entry.column;
                        line_in = head_entry.row;
                     end
                     out_load = 1'b1;
                  end
                  tccw_pkg::OP_SCROLL: begin
                     scroll_req = 1'b1;
                     sc_lines   = head_entry.lines;
                  end
                  tccw_pkg::OP_READ: begin
                     if (head_entry.bad) begin
                        out_status = 1'b1;
                        out_load   = 1'b1;
                     end else begin
                        state_in = tccw_pkg::B_READ;
                     end
                  end
                  default: out_load = 1'b1;
               endcase
            end
         end
         tccw_pkg::B_TAB: begin
            state_in = tccw_pkg::B_IDLE;
            if (tab_next >= NEXT_W'(COLUMNS)) begin
               nl_req = 1'b1;
            end else begin
               col_in   = tab_next[COL_W-1:0];
               out_load = 1'b1;
            end
         end
         tccw_pkg::B_READ: begin
            out_load = 1'b1;
            out_char = rd_data[7:0];
            out_attr = rd_data[15:8];
            state_in = tccw_pkg::B_IDLE;
         end
         tccw_pkg::B_COPY_RD: begin
            rd_addr  = ptr_ff + off_ff;
            state_in = tccw_pkg::B_COPY_WR;
         end
         tccw_pkg::B_COPY_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            ptr_in  = ptr_ff + 1'b1;
            state_in = (ptr_ff == end_ff - 1'b1) ? tccw_pkg::B_FILL : tccw_pkg::B_COPY_RD;
         end
         tccw_pkg::B_FILL: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = {fill_attr_ff, tccw_pkg::CHAR_SPACE};
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = tccw_pkg::B_IDLE;
               out_load = respond_ff;
            end
         end
         default: state_in = tccw_pkg::B_IDLE;
      endcase

      // newline: next row, or a one-line scroll from the bottom row
      if (nl_req) begin
         col_in = '0;
         if (line_ff < ROW_W'(ROWS - 1)) begin
            line_in  = line_ff + 1'b1;
            out_load = 1'b1;
         end else begin
            scroll_req = 1'b1;
            sc_lines   = LINES_W'(1);
         end
      end

      if (scroll_req) begin
         off_in       = off_full[ADDR_W-1:0];
         end_in       = ADDR_W'(keep_rows) * ADDR_W'(COLUMNS);
         fill_attr_in = text_attr;
         respond_in   = 1'b1;
         if (keep_rows != '0) begin
            ptr_in   = '0;
            state_in = tccw_pkg::B_COPY_RD;
         end else begin
            ptr_in   = '0;
            state_in = tccw_pkg::B_FILL;
         end
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = out_status;
         rsp_in.cursor_column  = col_in;
         rsp_in.cursor_row     = line_in;
         rsp_in.cell_char      = out_char;
         rsp_in.cell_attribute = out_attr;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tccw_pkg::B_FILL;
         ptr_ff       <= '0;
         fill_attr_ff <= tccw_pkg::TEXT_ATTR_RESET;
         respond_ff   <= 1'b0;
         col_ff       <= '0;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fill_attr_ff <= fill_attr_in;
         respond_ff   <= respond_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff   <= off_in;
      end_ff   <= end_in;
      tab_q_ff <= tab_q_in;
      rsp_ff   <= rsp_in;
   end

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < COLUMNS) && (32'(line_ff) < ROWS))
      else $error("cursor out of screen range");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tccw_pkg::B_IDLE) |-> !pop)
      else $error("queue popped while engine busy");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(rsp_ff) && rsp_valid_ff))
      else $error("pending result overwritten");

   a_copy_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tccw_pkg::B_COPY_WR) |-> ($past(state_ff) == tccw_pkg::B_COPY_RD))
      else $error("copy write without preceding read");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < CELL_COUNT))
      else $error("screen write outside the store");

endmodule

// File: rtl/core/text_console_cell_writer_top.sv
// text console cell writer: a character/attribute screen with a cursor
//
// req channel: one command item per handshake (write char, clear, set cursor,
//   scroll up, read cell); the front end classifies it and parks it in a
//   two-entry queue, so req_tready only drops when the queue is full
// rsp channel: exactly one result item per command, in order, from an output
//   register; while the receiver stalls, the engine finishes the current item
//   and the queue keeps taking new items until it fills
// csr port: text_attribute at byte address 0, written in the apb access cycle
// engine: write char, carriage return, backspace, set cursor and rejected
//   reads are done in the idle state, tab and accepted reads go on to B_TAB
//   (reciprocal step) or B_READ (registered ram read); clear blanks every
//   cell in B_FILL, a scroll of n lines copies the kept rows up (B_COPY_RD,
//   B_COPY_WR per cell) and blanks the n freed rows in B_FILL, all bound by the
//   single write port of the screen ram; a newline, wrap or tab off the bottom
//   row runs a one-line scroll
// results: each shows at the edge that ends the engine's last cycle for its item
// reset: cursor to 0,0, text_attribute to 0x07, then a clearing pass over all
//   COLUMNS*ROWS cells (2000 by default) blanks the screen; items wait in the
//   queue meanwhile, csr writes are taken as ever
module text_console_cell_writer_top #(
   parameter int COLUMNS   = tccw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS      = tccw_pkg::DEFAULT_ROWS,
   parameter int TAB_WIDTH = tccw_pkg::DEFAULT_TAB_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   // request items
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[7:0], column[14:8], row[19:15], scroll_count[27:20], zero above
   input  logic [31:0] req_tdata,
   // command[2:0]
   input  logic [2:0]  req_tuser,
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_column[6:0], cursor_row[11:7], cell_char[19:12],
   // cell_attribute[27:20], zero above
   output logic [31:0] rsp_tdata,
   // status[0]
   output logic [0:0]  rsp_tuser,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [tccw_pkg::ATTR_W-1:0] text_attr_ff, text_attr_in;
   logic                 push_valid, push_ready;
   tccw_pkg::entry_type  push_entry, head_entry;
   logic                 head_valid, pop;
   logic                 rsp_valid;
   tccw_pkg::result_type rsp_result;
   logic                 csr_write;

   // apb register: word index in paddr[2], byte offsets ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == tccw_pkg::REG_TEXT_ATTR) ? 32'(text_attr_ff) : '0;

   always_comb begin
      text_attr_in = text_attr_ff;
      if (csr_write && (csr_paddr[2] == tccw_pkg::REG_TEXT_ATTR)) begin
         text_attr_in = csr_pwdata[tccw_pkg::ATTR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff <= tccw_pkg::TEXT_ATTR_RESET;
      end else begin
         text_attr_ff <= text_attr_in;
      end
   end

   // front end: decode command and character class
   tccw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decoupling queue between front end and engine
   tccw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .head_entry (head_entry)
   );

   // engine: cursor, screen ram walks, result register
   tccw_back #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .text_attr  (text_attr_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tuser  = rsp_result.status;
   assign rsp_tdata  = {4'd0, rsp_result.cell_attribute, rsp_result.cell_char,
                        rsp_result.cursor_row, rsp_result.cursor_column};

endmodule
